// ===== hw/rtl/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP response deframer package
// Shared types, codes and character helpers for the deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

   localparam int unsigned LINE_BYTES = 512;
   localparam int unsigned LENGTH_CAP = 67108864;
   localparam int unsigned LEN_W      = 27;
   localparam int unsigned LINE_W     = 10;

   typedef enum logic [2:0] {
      RS_MORE   = 3'd0,
      RS_DONE   = 3'd1,
      RS_PARSE  = 3'd2,
      RS_STATUS = 3'd3,
      RS_TOOBIG = 3'd4
   } result_type;

   typedef enum logic [3:0] {
      PH_STATUS     = 4'd0,
      PH_HEADERS    = 4'd1,
      PH_BODY_LEN   = 4'd2,
      PH_CHUNK_SIZE = 4'd3,
      PH_CHUNK_DATA = 4'd4,
      PH_CHUNK_CRLF = 4'd5,
      PH_BODY_EOF   = 4'd6,
      PH_COMPLETE   = 4'd7,
      PH_ERROR      = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      FR_UNKNOWN = 2'd0,
      FR_LENGTH  = 2'd1,
      FR_CHUNKED = 2'd2,
      FR_EOF     = 2'd3
   } framing_type;

   typedef enum logic [2:0] {
      LK_NONE  = 3'd0,
      LK_OTHER = 3'd1,
      LK_CLEN  = 3'd2,
      LK_TENC  = 3'd3,
      LK_BAD   = 3'd4
   } line_kind_type;

   typedef enum logic [1:0] {
      VP_PREFIX = 2'd0,
      VP_WS     = 2'd1,
      VP_VALUE  = 2'd2,
      VP_DONE   = 2'd3
   } value_phase_type;

   localparam int unsigned CSR_BODY_LIMIT   = 0;
   localparam int unsigned CSR_HEADER_LIMIT = 1;

   // Result of one parsed transaction, carried to the output stage.
   typedef struct packed {
      result_type  status;
      logic        body_valid;
      logic [7:0]  body_byte;
      logic [9:0]  code;
      logic        redirect;
      framing_type framing;
   } result_pkt_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == 8'h20 || c == 8'h09);
   endfunction

   // Hex digit value; bit 4 set when the byte is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         hex_value = {1'b0, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         hex_value = {1'b0, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         hex_value = {1'b0, t[3:0]};
      end else begin
         hex_value = 5'h10;
      end
   endfunction

   // Lower-case header names, indexed by position in the line.
   function automatic logic [7:0] clen_char(input logic [LINE_W-1:0] pos);
      case (pos)
         10'd0:  clen_char = "c";
         10'd1:  clen_char = "o";
         10'd2:  clen_char = "n";
         10'd3:  clen_char = "t";
         10'd4:  clen_char = "e";
         10'd5:  clen_char = "n";
         10'd6:  clen_char = "t";
         10'd7:  clen_char = "-";
         10'd8:  clen_char = "l";
         10'd9:  clen_char = "e";
         10'd10: clen_char = "n";
         10'd11: clen_char = "g";
         10'd12: clen_char = "t";
         10'd13: clen_char = "h";
         10'd14: clen_char = ":";
         default: clen_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tenc_char(input logic [LINE_W-1:0] pos);
      case (pos)
         10'd0:  tenc_char = "t";
         10'd1:  tenc_char = "r";
         10'd2:  tenc_char = "a";
         10'd3:  tenc_char = "n";
         10'd4:  tenc_char = "s";
         10'd5:  tenc_char = "f";
         10'd6:  tenc_char = "e";
         10'd7:  tenc_char = "r";
         10'd8:  tenc_char = "-";
         10'd9:  tenc_char = "e";
         10'd10: tenc_char = "n";
         10'd11: tenc_char = "c";
         10'd12: tenc_char = "o";
         10'd13: tenc_char = "d";
         10'd14: tenc_char = "i";
         10'd15: tenc_char = "n";
         10'd16: tenc_char = "g";
         10'd17: tenc_char = ":";
         default: tenc_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] http_char(input logic [LINE_W-1:0] pos);
      case (pos)
         10'd0: http_char = "h";
         10'd1: http_char = "t";
         10'd2: http_char = "t";
         10'd3: http_char = "p";
         10'd4: http_char = "/";
         default: http_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] chunked_char(input logic [2:0] pos);
      case (pos)
         3'd0: chunked_char = "c";
         3'd1: chunked_char = "h";
         3'd2: chunked_char = "u";
         3'd3: chunked_char = "n";
         3'd4: chunked_char = "k";
         3'd5: chunked_char = "e";
         3'd6: chunked_char = "d";
         default: chunked_char = 8'h00;
      endcase
   endfunction

   function automatic logic is_redirect_code(input logic [9:0] v);
      is_redirect_code = (v == 10'd301 || v == 10'd302 || v == 10'd303 ||
                          v == 10'd307 || v == 10'd308);
   endfunction

endpackage

// ===== hw/rtl/http_response_deframer.sv =====
// ----------------------------------------------------------------------------
// HTTP response deframer
// Byte-serial HTTP/1.1 response parser with streaming body output.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one response byte (req_func 0) or an
// end-of-stream marker (req_func 1) per transaction. Each accepted transaction
// yields exactly one rsp transaction with the running result status, the body
// byte when the byte belongs to the body, the status code, the redirect flag
// and the framing kind.
// The input is registered at acceptance and parsed into the output register
// whenever that register is free.
// Throughput: one transaction per cycle unless the receiver stalls; the parse
// logic between the input and result registers carries all per-byte state
// updates. A stalled receiver holds the output register; the input register
// then takes one more transaction and req_ready stays low until the output
// drains. Reset clears all parse state, restores the default limits and
// empties both registers. The user must write limits through the csr port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module http_response_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_status,
   output logic        rsp_body_valid,
   output logic [7:0]  rsp_body_byte,
   output logic [9:0]  rsp_response_code,
   output logic        rsp_is_redirect,
   output logic [1:0]  rsp_framing_kind,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [26:0] csr_data
);

   logic                      in_valid_ff;
   logic                      in_func_ff;
   logic [7:0]                in_byte_ff;
   logic                      out_valid_ff;
   hrd_pkg::result_pkt_type   out_ff;
   hrd_pkg::result_pkt_type   result;
   logic [hrd_pkg::LEN_W-1:0] body_limit_ff;
   logic [15:0]               header_limit_ff;
   logic                      step;
   logic                      out_free;

   // The result register is free when empty or drained this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff   <= 27'(hrd_pkg::LENGTH_CAP);
         header_limit_ff <= 16'd8192;
      end else if (csr_write) begin
         if (csr_index == 1'(hrd_pkg::CSR_BODY_LIMIT))
            body_limit_ff <= csr_data;
         else
            header_limit_ff <= csr_data[15:0];
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_data_byte;
      end
   end

   hrd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .func         (in_func_ff),
      .data_byte    (in_byte_ff),
      .body_limit   (body_limit_ff),
      .header_limit (header_limit_ff),
      .result       (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) out_ff <= result;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_status = out_ff.status;
   assign rsp_body_valid    = out_ff.body_valid;
   assign rsp_body_byte     = out_ff.body_byte;
   assign rsp_response_code = out_ff.code;
   assign rsp_is_redirect   = out_ff.redirect;
   assign rsp_framing_kind  = out_ff.framing;

`ifndef SYNTHESIS
   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("result changed while stalled");

   // A body byte never carries an error status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_valid |-> rsp_result_status != hrd_pkg::RS_PARSE &&
      rsp_result_status != hrd_pkg::RS_TOOBIG && rsp_result_status != hrd_pkg::RS_STATUS)
      else $error("body byte with error status");

   // A pending input is held while the parse stage cannot move.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending input lost");
`endif

endmodule

// ===== hw/rtl/hrd_parser.sv =====
// ----------------------------------------------------------------------------
// HTTP response deframer parser core
// Holds the framing state and works one registered transaction per cycle while step is high.
// ----------------------------------------------------------------------------
module hrd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       func,
   input  logic [7:0]                 data_byte,
   input  logic [hrd_pkg::LEN_W-1:0]  body_limit,
   input  logic [15:0]                header_limit,
   output hrd_pkg::result_pkt_type    result
);

   hrd_pkg::phase_type       phase_ff, phase_in;
   hrd_pkg::framing_type     framing_ff, framing_in;
   hrd_pkg::line_kind_type   kind_ff, kind_in;
   hrd_pkg::value_phase_type vph_ff, vph_in;
   logic [9:0]                status_ff, status_in;
   logic [hrd_pkg::LEN_W-1:0] blen_ff, blen_in;
   logic [hrd_pkg::LEN_W-1:0] bcnt_ff, bcnt_in;
   logic [hrd_pkg::LEN_W-1:0] cleft_ff, cleft_in;
   logic [hrd_pkg::LEN_W-1:0] acc_ff, acc_in;
   logic [15:0]               hcnt_ff, hcnt_in;
   logic [hrd_pkg::LINE_W-1:0] lcnt_ff, lcnt_in;
   logic                      frozen_ff, frozen_in;

   // State registers, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hrd_pkg::PH_STATUS;
         framing_ff <= hrd_pkg::FR_UNKNOWN;
         kind_ff    <= hrd_pkg::LK_NONE;
         vph_ff     <= hrd_pkg::VP_PREFIX;
         status_ff  <= '0;
         blen_ff    <= '0;
         bcnt_ff    <= '0;
         cleft_ff   <= '0;
         acc_ff     <= '0;
         hcnt_ff    <= '0;
         lcnt_ff    <= '0;
         frozen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         framing_ff <= framing_in;
         kind_ff    <= kind_in;
         vph_ff     <= vph_in;
         status_ff  <= status_in;
         blen_ff    <= blen_in;
         bcnt_ff    <= bcnt_in;
         cleft_ff   <= cleft_in;
         acc_ff     <= acc_in;
         hcnt_ff    <= hcnt_in;
         lcnt_ff    <= lcnt_in;
         frozen_ff  <= frozen_in;
      end
   end

   logic [7:0]  lc;
   logic [4:0]  hv;
   logic [31:0] dec_next, hex_next;
   logic [16:0] hcnt_inc;
   logic [hrd_pkg::LEN_W:0] bcnt_inc;
   logic        body_ok;
   logic [9:0]  dig;
   hrd_pkg::result_type res;
   logic        bvalid;

   assign lc       = hrd_pkg::to_lower(data_byte);
   assign hv       = hrd_pkg::hex_value(data_byte);
   assign dig      = {2'b0, data_byte - 8'h30};
   assign dec_next = {5'b0, acc_ff} * 32'd10 + {28'b0, dig[3:0]};
   assign hex_next = {1'b0, acc_ff, 4'b0} + {28'b0, hv[3:0]};
   assign hcnt_inc = {1'b0, hcnt_ff} + 17'd1;
   assign bcnt_inc = {1'b0, bcnt_ff} + 1'b1;
   assign body_ok  = bcnt_inc <= {1'b0, body_limit};

   // Next state and result for one transaction.
   always_comb begin
      phase_in   = phase_ff;
      framing_in = framing_ff;
      kind_in    = kind_ff;
      vph_in     = vph_ff;
      status_in  = status_ff;
      blen_in    = blen_ff;
      bcnt_in    = bcnt_ff;
      cleft_in   = cleft_ff;
      acc_in     = acc_ff;
      hcnt_in    = hcnt_ff;
      lcnt_in    = lcnt_ff;
      frozen_in  = frozen_ff;
      res        = hrd_pkg::RS_MORE;
      bvalid     = 1'b0;

      if (func) begin
         if (phase_ff == hrd_pkg::PH_COMPLETE) begin
            res = hrd_pkg::RS_DONE;
         end else if (phase_ff == hrd_pkg::PH_BODY_EOF) begin
            phase_in = hrd_pkg::PH_COMPLETE;
            res      = hrd_pkg::RS_DONE;
         end else begin
            res = hrd_pkg::RS_PARSE;
         end
      end else begin
         case (phase_ff)
            hrd_pkg::PH_STATUS, hrd_pkg::PH_HEADERS: begin
               if (hcnt_inc > {1'b0, header_limit}) begin
                  res = hrd_pkg::RS_TOOBIG;
               end else begin
                  hcnt_in = hcnt_inc[15:0];
                  if (data_byte == 8'h0D) begin
                     res = hrd_pkg::RS_MORE;
                  end else if (data_byte == 8'h0A) begin
                     // End of a head line.
                     if (phase_ff == hrd_pkg::PH_STATUS) begin
                        if (kind_ff == hrd_pkg::LK_BAD || vph_ff == hrd_pkg::VP_PREFIX ||
                            vph_ff == hrd_pkg::VP_WS || acc_ff < 27'd100 ||
                            acc_ff > 27'd599) begin
                           res = hrd_pkg::RS_PARSE;
                        end else begin
                           status_in = acc_ff[9:0];
                           phase_in  = hrd_pkg::PH_HEADERS;
                        end
                     end else if (lcnt_ff == '0) begin
                        if (hrd_pkg::is_redirect_code(status_ff)) begin
                           phase_in = hrd_pkg::PH_COMPLETE;
                           res      = hrd_pkg::RS_DONE;
                        end else if (status_ff < 10'd200 || status_ff >= 10'd300) begin
                           res = hrd_pkg::RS_STATUS;
                        end else if (framing_ff == hrd_pkg::FR_CHUNKED) begin
                           phase_in = hrd_pkg::PH_CHUNK_SIZE;
                        end else if (framing_ff == hrd_pkg::FR_LENGTH) begin
                           if (blen_ff == '0) begin
                              phase_in = hrd_pkg::PH_COMPLETE;
                              res      = hrd_pkg::RS_DONE;
                           end else begin
                              phase_in = hrd_pkg::PH_BODY_LEN;
                           end
                        end else begin
                           framing_in = hrd_pkg::FR_EOF;
                           phase_in   = hrd_pkg::PH_BODY_EOF;
                        end
                     end else if (kind_ff == hrd_pkg::LK_BAD) begin
                        res = hrd_pkg::RS_PARSE;
                     end else if (kind_ff == hrd_pkg::LK_CLEN &&
                                  vph_ff != hrd_pkg::VP_PREFIX) begin
                        if (vph_ff == hrd_pkg::VP_WS) begin
                           res = hrd_pkg::RS_PARSE;
                        end else if (framing_ff != hrd_pkg::FR_CHUNKED) begin
                           framing_in = hrd_pkg::FR_LENGTH;
                           blen_in    = acc_ff;
                        end
                     end else if (kind_ff == hrd_pkg::LK_TENC &&
                                  vph_ff == hrd_pkg::VP_DONE && acc_ff == 27'd7) begin
                        framing_in = hrd_pkg::FR_CHUNKED;
                        blen_in    = '0;
                     end
                     lcnt_in   = '0;
                     kind_in   = hrd_pkg::LK_NONE;
                     acc_in    = '0;
                     vph_in    = hrd_pkg::VP_PREFIX;
                     frozen_in = 1'b0;
                  end else if ({1'b0, lcnt_ff} + 11'd1 >= 11'(hrd_pkg::LINE_BYTES)) begin
                     res = hrd_pkg::RS_TOOBIG;
                  end else begin
                     lcnt_in = lcnt_ff + 1'b1;
                     if (data_byte == 8'h00) frozen_in = 1'b1;
                     if (!(frozen_ff || data_byte == 8'h00)) begin
                        if (phase_ff == hrd_pkg::PH_STATUS) begin
                           // Status line: protocol name, then the code.
                           if (kind_ff != hrd_pkg::LK_BAD) begin
                              if (lcnt_ff < 10'd5) begin
                                 if (lc != hrd_pkg::http_char(lcnt_ff))
                                    kind_in = hrd_pkg::LK_BAD;
                              end else if (vph_ff == hrd_pkg::VP_PREFIX) begin
                                 if (data_byte == 8'h20) vph_in = hrd_pkg::VP_WS;
                              end else if (vph_ff == hrd_pkg::VP_WS) begin
                                 if (!hrd_pkg::is_blank(data_byte)) begin
                                    if (hrd_pkg::is_digit(data_byte)) begin
                                       acc_in = {23'b0, dig[3:0]};
                                       vph_in = hrd_pkg::VP_VALUE;
                                    end else begin
                                       kind_in = hrd_pkg::LK_BAD;
                                       vph_in  = hrd_pkg::VP_DONE;
                                    end
                                 end
                              end else if (vph_ff == hrd_pkg::VP_VALUE) begin
                                 if (hrd_pkg::is_digit(data_byte)) begin
                                    if (dec_next > 32'(hrd_pkg::LENGTH_CAP)) begin
                                       kind_in = hrd_pkg::LK_BAD;
                                       vph_in  = hrd_pkg::VP_DONE;
                                    end else begin
                                       acc_in = dec_next[hrd_pkg::LEN_W-1:0];
                                    end
                                 end else begin
                                    vph_in = hrd_pkg::VP_DONE;
                                 end
                              end
                           end
                        end else if (kind_ff == hrd_pkg::LK_NONE) begin
                           kind_in = (lc == 8'h63) ? hrd_pkg::LK_CLEN :
                                     (lc == 8'h74) ? hrd_pkg::LK_TENC : hrd_pkg::LK_OTHER;
                        end else if (kind_ff == hrd_pkg::LK_CLEN ||
                                     kind_ff == hrd_pkg::LK_TENC) begin
                           if (vph_ff == hrd_pkg::VP_PREFIX) begin
                              // Match the header name as it arrives.
                              if (kind_ff == hrd_pkg::LK_CLEN) begin
                                 if (lcnt_ff >= 10'd15 || lc != hrd_pkg::clen_char(lcnt_ff))
                                    kind_in = hrd_pkg::LK_OTHER;
                                 else if (lcnt_ff == 10'd14)
                                    vph_in = hrd_pkg::VP_WS;
                              end else begin
                                 if (lcnt_ff >= 10'd18 || lc != hrd_pkg::tenc_char(lcnt_ff))
                                    kind_in = hrd_pkg::LK_OTHER;
                                 else if (lcnt_ff == 10'd17)
                                    vph_in = hrd_pkg::VP_WS;
                              end
                           end else if (kind_ff == hrd_pkg::LK_CLEN) begin
                              if (vph_ff == hrd_pkg::VP_WS) begin
                                 if (!hrd_pkg::is_blank(data_byte)) begin
                                    if (hrd_pkg::is_digit(data_byte)) begin
                                       acc_in = {23'b0, dig[3:0]};
                                       vph_in = hrd_pkg::VP_VALUE;
                                    end else begin
                                       kind_in = hrd_pkg::LK_BAD;
                                       vph_in  = hrd_pkg::VP_DONE;
                                    end
                                 end
                              end else if (vph_ff == hrd_pkg::VP_VALUE) begin
                                 if (hrd_pkg::is_digit(data_byte)) begin
                                    if (dec_next > 32'(hrd_pkg::LENGTH_CAP)) begin
                                       kind_in = hrd_pkg::LK_BAD;
                                       vph_in  = hrd_pkg::VP_DONE;
                                    end else begin
                                       acc_in = dec_next[hrd_pkg::LEN_W-1:0];
                                    end
                                 end else begin
                                    vph_in = hrd_pkg::VP_DONE;
                                 end
                              end
                           end else begin
                              // Transfer-encoding value must start with chunked.
                              if (vph_ff == hrd_pkg::VP_WS) begin
                                 if (!hrd_pkg::is_blank(lc)) begin
                                    if (lc == 8'h63) begin
                                       acc_in = 27'd1;
                                       vph_in = hrd_pkg::VP_VALUE;
                                    end else begin
                                       acc_in = '0;
                                       vph_in = hrd_pkg::VP_DONE;
                                    end
                                 end
                              end else if (vph_ff == hrd_pkg::VP_VALUE) begin
                                 if (lc == hrd_pkg::chunked_char(acc_ff[2:0])) begin
                                    if (acc_ff + 27'd1 >= 27'd7) begin
                                       acc_in = 27'd7;
                                       vph_in = hrd_pkg::VP_DONE;
                                    end else begin
                                       acc_in = acc_ff + 27'd1;
                                    end
                                 end else begin
                                    acc_in = '0;
                                    vph_in = hrd_pkg::VP_DONE;
                                 end
                              end
                           end
                        end
                     end
                  end
               end
            end
            hrd_pkg::PH_BODY_LEN: begin
               if (!body_ok) begin
                  res = hrd_pkg::RS_TOOBIG;
               end else begin
                  bcnt_in = bcnt_inc[hrd_pkg::LEN_W-1:0];
                  bvalid  = 1'b1;
                  if (bcnt_inc >= {1'b0, blen_ff}) begin
                     phase_in = hrd_pkg::PH_COMPLETE;
                     res      = hrd_pkg::RS_DONE;
                  end
               end
            end
            hrd_pkg::PH_CHUNK_SIZE: begin
               if (data_byte == 8'h0D) begin
                  res = hrd_pkg::RS_MORE;
               end else if (data_byte == 8'h0A) begin
                  lcnt_in   = '0;
                  kind_in   = hrd_pkg::LK_NONE;
                  acc_in    = '0;
                  vph_in    = hrd_pkg::VP_PREFIX;
                  frozen_in = 1'b0;
                  if (kind_ff == hrd_pkg::LK_BAD || vph_ff == hrd_pkg::VP_PREFIX) begin
                     res = hrd_pkg::RS_PARSE;
                  end else if (acc_ff == '0) begin
                     phase_in = hrd_pkg::PH_COMPLETE;
                     res      = hrd_pkg::RS_DONE;
                  end else begin
                     cleft_in = acc_ff;
                     phase_in = hrd_pkg::PH_CHUNK_DATA;
                  end
               end else if ({1'b0, lcnt_ff} + 11'd1 >= 11'(hrd_pkg::LINE_BYTES)) begin
                  res = hrd_pkg::RS_TOOBIG;
               end else begin
                  lcnt_in = lcnt_ff + 1'b1;
                  if (data_byte == 8'h00) frozen_in = 1'b1;
                  if (!(frozen_ff || data_byte == 8'h00) && kind_ff != hrd_pkg::LK_BAD) begin
                     if (vph_ff == hrd_pkg::VP_PREFIX) begin
                        if (!hv[4]) begin
                           acc_in = {23'b0, hv[3:0]};
                           vph_in = hrd_pkg::VP_VALUE;
                        end else begin
                           kind_in = hrd_pkg::LK_BAD;
                        end
                     end else if (vph_ff == hrd_pkg::VP_VALUE) begin
                        if (!hv[4]) begin
                           if (hex_next > 32'(hrd_pkg::LENGTH_CAP)) begin
                              kind_in = hrd_pkg::LK_BAD;
                              vph_in  = hrd_pkg::VP_DONE;
                           end else begin
                              acc_in = hex_next[hrd_pkg::LEN_W-1:0];
                           end
                        end else begin
                           vph_in = hrd_pkg::VP_DONE;
                        end
                     end
                  end
               end
            end
            hrd_pkg::PH_CHUNK_DATA: begin
               if (!body_ok) begin
                  res = hrd_pkg::RS_TOOBIG;
               end else begin
                  bcnt_in = bcnt_inc[hrd_pkg::LEN_W-1:0];
                  bvalid  = 1'b1;
                  if (cleft_ff <= 27'd1) begin
                     cleft_in = '0;
                     phase_in = hrd_pkg::PH_CHUNK_CRLF;
                  end else begin
                     cleft_in = cleft_ff - 27'd1;
                  end
               end
            end
            hrd_pkg::PH_CHUNK_CRLF: begin
               if (data_byte == 8'h0A) phase_in = hrd_pkg::PH_CHUNK_SIZE;
            end
            hrd_pkg::PH_BODY_EOF: begin
               if (!body_ok) begin
                  res = hrd_pkg::RS_TOOBIG;
               end else begin
                  bcnt_in = bcnt_inc[hrd_pkg::LEN_W-1:0];
                  bvalid  = 1'b1;
               end
            end
            hrd_pkg::PH_COMPLETE: begin
               res = hrd_pkg::RS_DONE;
            end
            default: begin
               res = hrd_pkg::RS_PARSE;
            end
         endcase
      end

      if (res == hrd_pkg::RS_PARSE || res == hrd_pkg::RS_STATUS ||
          res == hrd_pkg::RS_TOOBIG)
         phase_in = hrd_pkg::PH_ERROR;

      result.status     = res;
      result.body_valid = bvalid;
      result.body_byte  = bvalid ? data_byte : 8'h00;
      result.code       = status_in;
      result.redirect   = hrd_pkg::is_redirect_code(status_in);
      result.framing    = framing_in;
   end

endmodule

// ===== tb/tb_http_response_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response deframer testbench
// Sends whole HTTP responses and stray bytes through the request channel.
// A predictor of the parse rules computes each expected result, and a
// scoreboard compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_http_response_deframer;

   // Expected result of one transaction.
   typedef struct {
      hrd_pkg::result_type  status;
      logic                 body_valid;
      logic [7:0]           body_byte;
      logic [9:0]           code;
      logic                 redirect;
      hrd_pkg::framing_type framing;
   } parse_result_type;

   // Keeps the expected results in order and checks actual results.
   class deframe_scoreboard;
      parse_result_type pending[$];
      int errors;
      int checked;

      function void note_request(parse_result_type r);
         pending.push_back(r);
      endfunction

      function void check_result(parse_result_type a);
         parse_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, status %0d", $time, a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
         if (a.body_valid !== e.body_valid)
            $display("%0t: body_valid expected %0d actual %0d", $time, e.body_valid,
                     a.body_valid);
         if (a.body_byte !== e.body_byte)
            $display("%0t: body_byte expected %0h actual %0h", $time, e.body_byte,
                     a.body_byte);
         if (a.code !== e.code)
            $display("%0t: code expected %0d actual %0d", $time, e.code, a.code);
         if (a.redirect !== e.redirect)
            $display("%0t: redirect expected %0d actual %0d", $time, e.redirect,
                     a.redirect);
         if (a.framing !== e.framing)
            $display("%0t: framing expected %0d actual %0d", $time, e.framing,
                     a.framing);
         if (a.status !== e.status || a.body_valid !== e.body_valid ||
             a.body_byte !== e.body_byte || a.code !== e.code ||
             a.redirect !== e.redirect || a.framing !== e.framing)
            errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_result_status;
   logic        rsp_body_valid;
   logic [7:0]  rsp_body_byte;
   logic [9:0]  rsp_response_code;
   logic        rsp_is_redirect;
   logic [1:0]  rsp_framing_kind;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [26:0] csr_data;

   http_response_deframer uut (.*);

   deframe_scoreboard board;

   // Predictor state.
   logic [26:0]              lim_body;
   logic [15:0]              lim_head;
   hrd_pkg::phase_type       ph;
   hrd_pkg::framing_type     frm;
   logic [9:0]               code_q;
   logic [26:0]              blen;
   logic [26:0]              bcount;
   logic [26:0]              cleft;
   logic [15:0]              hcount;
   int unsigned              lcount;
   hrd_pkg::line_kind_type   lkind;
   int unsigned              vacc;
   hrd_pkg::value_phase_type vph;
   bit                       frozen;

   int  sent;
   int  responses_done;
   bit  hold_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int hexval(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      return -1;
   endfunction

   function automatic bit redir();
      return code_q == 301 || code_q == 302 || code_q == 303 ||
             code_q == 307 || code_q == 308;
   endfunction

   function automatic void line_reset();
      lcount = 0;
      lkind = hrd_pkg::LK_NONE;
      vacc = 0;
      vph = hrd_pkg::VP_PREFIX;
      frozen = 0;
   endfunction

   function automatic void reset_model();
      lim_body = 27'd67108864;
      lim_head = 16'd8192;
      ph = hrd_pkg::PH_STATUS;
      frm = hrd_pkg::FR_UNKNOWN;
      code_q = 0;
      blen = 0;
      bcount = 0;
      cleft = 0;
      hcount = 0;
      line_reset();
   endfunction

   // Decimal value scan for the status code and content-length.
   function automatic void scan_decimal(logic [7:0] c);
      int unsigned v;
      if (vph == hrd_pkg::VP_WS) begin
         if (c == " " || c == 8'h09) return;
         if (digit(c)) begin
            vacc = 32'(c - 8'h30);
            vph = hrd_pkg::VP_VALUE;
         end else begin
            lkind = hrd_pkg::LK_BAD;
            vph = hrd_pkg::VP_DONE;
         end
      end else if (vph == hrd_pkg::VP_VALUE) begin
         if (digit(c)) begin
            v = vacc * 10 + 32'(c - 8'h30);
            if (v > hrd_pkg::LENGTH_CAP) begin
               lkind = hrd_pkg::LK_BAD;
               vph = hrd_pkg::VP_DONE;
            end else vacc = v;
         end else vph = hrd_pkg::VP_DONE;
      end
   endfunction

   // Matches the word chunked at the start of a transfer-encoding value.
   function automatic void scan_chunked(logic [7:0] lc);
      string w;
      w = "chunked";
      if (vph == hrd_pkg::VP_WS) begin
         if (lc == " " || lc == 8'h09) return;
         if (lc == "c") begin
            vacc = 1;
            vph = hrd_pkg::VP_VALUE;
         end else begin
            vacc = 0;
            vph = hrd_pkg::VP_DONE;
         end
      end else if (vph == hrd_pkg::VP_VALUE) begin
         if (lc == w[vacc & 7]) begin
            vacc++;
            if (vacc >= 7) begin
               vacc = 7;
               vph = hrd_pkg::VP_DONE;
            end
         end else begin
            vacc = 0;
            vph = hrd_pkg::VP_DONE;
         end
      end
   endfunction

   function automatic void head_char(int unsigned pos, logic [7:0] c);
      string pat;
      logic [7:0] lc;
      lc = lower(c);
      if (ph == hrd_pkg::PH_STATUS) begin
         pat = "http/";
         if (lkind == hrd_pkg::LK_BAD) return;
         if (pos < 5) begin
            if (lc != pat[pos]) lkind = hrd_pkg::LK_BAD;
            return;
         end
         if (vph == hrd_pkg::VP_PREFIX) begin
            if (c == " ") vph = hrd_pkg::VP_WS;
            return;
         end
         scan_decimal(c);
         return;
      end
      if (lkind == hrd_pkg::LK_NONE) begin
         lkind = (lc == "c") ? hrd_pkg::LK_CLEN :
                 (lc == "t") ? hrd_pkg::LK_TENC : hrd_pkg::LK_OTHER;
         return;
      end
      if (lkind != hrd_pkg::LK_CLEN && lkind != hrd_pkg::LK_TENC) return;
      if (vph == hrd_pkg::VP_PREFIX) begin
         pat = (lkind == hrd_pkg::LK_CLEN) ? "content-length:" : "transfer-encoding:";
         if (pos >= pat.len() || lc != pat[pos]) lkind = hrd_pkg::LK_OTHER;
         else if (pos == pat.len() - 1) vph = hrd_pkg::VP_WS;
         return;
      end
      if (lkind == hrd_pkg::LK_CLEN) scan_decimal(c);
      else scan_chunked(lc);
   endfunction

   // Decides what a line feed in the head of the response means.
   function automatic hrd_pkg::result_type head_line_end();
      if (ph == hrd_pkg::PH_STATUS) begin
         if (lkind == hrd_pkg::LK_BAD || vph < hrd_pkg::VP_VALUE) return hrd_pkg::RS_PARSE;
         if (vacc < 100 || vacc > 599) return hrd_pkg::RS_PARSE;
         code_q = vacc[9:0];
         ph = hrd_pkg::PH_HEADERS;
         return hrd_pkg::RS_MORE;
      end
      if (lcount == 0) begin
         if (redir()) begin
            ph = hrd_pkg::PH_COMPLETE;
            return hrd_pkg::RS_DONE;
         end
         if (code_q < 200 || code_q >= 300) return hrd_pkg::RS_STATUS;
         if (frm == hrd_pkg::FR_CHUNKED) ph = hrd_pkg::PH_CHUNK_SIZE;
         else if (frm == hrd_pkg::FR_LENGTH) begin
            if (blen == 0) begin
               ph = hrd_pkg::PH_COMPLETE;
               return hrd_pkg::RS_DONE;
            end
            ph = hrd_pkg::PH_BODY_LEN;
         end else begin
            frm = hrd_pkg::FR_EOF;
            ph = hrd_pkg::PH_BODY_EOF;
         end
         return hrd_pkg::RS_MORE;
      end
      if (lkind == hrd_pkg::LK_BAD) return hrd_pkg::RS_PARSE;
      if (lkind == hrd_pkg::LK_CLEN && vph != hrd_pkg::VP_PREFIX) begin
         if (vph == hrd_pkg::VP_WS) return hrd_pkg::RS_PARSE;
         if (frm != hrd_pkg::FR_CHUNKED) begin
            frm = hrd_pkg::FR_LENGTH;
            blen = vacc[26:0];
         end
      end else if (lkind == hrd_pkg::LK_TENC && vph == hrd_pkg::VP_DONE && vacc == 7) begin
         frm = hrd_pkg::FR_CHUNKED;
         blen = 0;
      end
      return hrd_pkg::RS_MORE;
   endfunction

   function automatic hrd_pkg::result_type head_byte(logic [7:0] c);
      hrd_pkg::result_type r;
      if (hcount + 17'd1 > {1'b0, lim_head}) return hrd_pkg::RS_TOOBIG;
      hcount++;
      if (c == 8'h0D) return hrd_pkg::RS_MORE;
      if (c == 8'h0A) begin
         r = head_line_end();
         line_reset();
         return r;
      end
      if (lcount + 1 >= hrd_pkg::LINE_BYTES) return hrd_pkg::RS_TOOBIG;
      if (c == 0) frozen = 1;
      if (!frozen) head_char(lcount, c);
      lcount++;
      return hrd_pkg::RS_MORE;
   endfunction

   function automatic hrd_pkg::result_type size_byte(logic [7:0] c);
      bit bad;
      int unsigned v;
      int d;
      if (c == 8'h0D) return hrd_pkg::RS_MORE;
      if (c == 8'h0A) begin
         bad = (lkind == hrd_pkg::LK_BAD) || (vph == hrd_pkg::VP_PREFIX);
         v = vacc;
         line_reset();
         if (bad) return hrd_pkg::RS_PARSE;
         if (v == 0) begin
            ph = hrd_pkg::PH_COMPLETE;
            return hrd_pkg::RS_DONE;
         end
         cleft = v[26:0];
         ph = hrd_pkg::PH_CHUNK_DATA;
         return hrd_pkg::RS_MORE;
      end
      if (lcount + 1 >= hrd_pkg::LINE_BYTES) return hrd_pkg::RS_TOOBIG;
      if (c == 0) frozen = 1;
      if (!frozen && lkind != hrd_pkg::LK_BAD) begin
         d = hexval(c);
         if (vph == hrd_pkg::VP_PREFIX) begin
            if (d >= 0) begin
               vacc = d;
               vph = hrd_pkg::VP_VALUE;
            end else lkind = hrd_pkg::LK_BAD;
         end else if (vph == hrd_pkg::VP_VALUE) begin
            if (d >= 0) begin
               v = vacc * 16 + d;
               if (v > hrd_pkg::LENGTH_CAP) begin
                  lkind = hrd_pkg::LK_BAD;
                  vph = hrd_pkg::VP_DONE;
               end else vacc = v;
            end else vph = hrd_pkg::VP_DONE;
         end
      end
      lcount++;
      return hrd_pkg::RS_MORE;
   endfunction

   function automatic bit body_ok();
      if ({1'b0, bcount} + 28'd1 > {1'b0, lim_body}) return 0;
      bcount++;
      return 1;
   endfunction

   // Advances the predictor by one transaction.
   function automatic parse_result_type predict(logic f, logic [7:0] c);
      parse_result_type r;
      hrd_pkg::result_type res;
      bit bv;
      res = hrd_pkg::RS_MORE;
      bv = 0;
      if (f) begin
         if (ph == hrd_pkg::PH_COMPLETE) res = hrd_pkg::RS_DONE;
         else if (ph == hrd_pkg::PH_BODY_EOF) begin
            ph = hrd_pkg::PH_COMPLETE;
            res = hrd_pkg::RS_DONE;
         end else res = hrd_pkg::RS_PARSE;
      end else begin
         case (ph)
            hrd_pkg::PH_STATUS, hrd_pkg::PH_HEADERS: res = head_byte(c);
            hrd_pkg::PH_BODY_LEN: begin
               if (!body_ok()) res = hrd_pkg::RS_TOOBIG;
               else begin
                  bv = 1;
                  if (bcount >= blen) begin
                     ph = hrd_pkg::PH_COMPLETE;
                     res = hrd_pkg::RS_DONE;
                  end
               end
            end
            hrd_pkg::PH_CHUNK_SIZE: res = size_byte(c);
            hrd_pkg::PH_CHUNK_DATA: begin
               if (!body_ok()) res = hrd_pkg::RS_TOOBIG;
               else begin
                  bv = 1;
                  if (cleft > 0) cleft--;
                  if (cleft == 0) ph = hrd_pkg::PH_CHUNK_CRLF;
               end
            end
            hrd_pkg::PH_CHUNK_CRLF: if (c == 8'h0A) ph = hrd_pkg::PH_CHUNK_SIZE;
            hrd_pkg::PH_BODY_EOF: begin
               if (!body_ok()) res = hrd_pkg::RS_TOOBIG;
               else bv = 1;
            end
            hrd_pkg::PH_COMPLETE: res = hrd_pkg::RS_DONE;
            default: res = hrd_pkg::RS_PARSE;
         endcase
      end
      if (res >= hrd_pkg::RS_PARSE) ph = hrd_pkg::PH_ERROR;
      if (res == hrd_pkg::RS_DONE && !f) responses_done++;
      r.status = res;
      r.body_valid = bv;
      r.body_byte = bv ? c : 8'h00;
      r.code = code_q;
      r.redirect = redir();
      r.framing = frm;
      return r;
   endfunction

   // Random gap, mostly short with an occasional long one. Valid drops only
   // when a gap is actually taken.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
      if ($urandom_range(0, 60) == 0) n = $urandom_range(10, 40);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offers one transaction and waits until it is accepted.
   task automatic send_item(logic f, logic [7:0] c);
      idle_gap();
      req_valid <= 1'b1;
      req_func <= f;
      req_data_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(predict(f, c));
      sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
   endtask

   task automatic send_body(int n);
      for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
   endtask

   // Stops offering and waits until every transaction has its result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(int idx, logic [26:0] v);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx[0:0];
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == hrd_pkg::CSR_BODY_LIMIT) lim_body = v;
      else lim_head = v[15:0];
   endtask

   // Receiver: random stalls and one long hold-off.
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(0, 5) != 0) ||
                           ($urandom_range(0, 1) == 0);
      end
   end

   initial begin
      parse_result_type a;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            a.status = hrd_pkg::result_type'(rsp_result_status);
            a.body_valid = rsp_body_valid;
            a.body_byte = rsp_body_byte;
            a.code = rsp_response_code;
            a.redirect = rsp_is_redirect;
            a.framing = hrd_pkg::framing_type'(rsp_framing_kind);
            board.check_result(a);
         end
      end
   end

   // Long receiver hold-off counted in cycles.
   task automatic long_hold();
      hold_rsp = 1;
      repeat (60) @(posedge clock);
      hold_rsp = 0;
   endtask

   // A well-formed response, head and body, with the framing chosen by kind.
   task automatic random_response(int kind);
      int n;
      send_text($urandom_range(0, 1) ? "HTTP/1.1 200 OK\r\n" : "http/1.0  204 x\n");
      if ($urandom_range(0, 1)) send_text("X-Junk: abc\r\n");
      case (kind)
         0: begin
            n = $urandom_range(0, 20);
            send_text($sformatf("Content-Length: %0d\r\n\r\n", n));
            send_body(n);
         end
         1: begin
            send_text("Transfer-Encoding: Chunked\r\n\r\n");
            repeat ($urandom_range(1, 3)) begin
               n = $urandom_range(1, 12);
               send_text($sformatf("%0h\r\n", n));
               send_body(n);
               send_text("\r\n");
            end
            send_text("0\r\n\r\n");
         end
         default: begin
            send_text("\r\n");
            send_body($urandom_range(0, 20));
            send_item(1'b1, 8'h00);
         end
      endcase
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_data_byte = 8'h00;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_data = 27'd0;
      hold_rsp = 0;
      sent = 0;
      responses_done = 0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: chunked response with a long receiver hold-off under way.
      fork
         long_hold();
      join_none
      write_csr(hrd_pkg::CSR_HEADER_LIMIT, 27'd65535);
      write_csr(hrd_pkg::CSR_BODY_LIMIT, 27'd67108864);
      send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\nTransfer-Encoding: chunked\r\n\r\n");
      send_text("A\r\n");
      send_body(10);
      send_text("xx\n0\r\n");
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'h00);

      // The stream is complete now; the rest of it exercises the terminal
      // answers with random bytes, end-of-stream items and new limits.
      write_csr(hrd_pkg::CSR_HEADER_LIMIT, 27'd1);
      write_csr(hrd_pkg::CSR_BODY_LIMIT, 27'd0);
      while (sent < 1750) begin
         if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
         else if ($urandom_range(0, 3) == 0) random_response($urandom_range(0, 2));
         else send_item(1'b0, 8'($urandom_range(0, 255)));
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Run covered %0d transactions, %0d result checks and %0d done answers.",
               sent, board.checked, responses_done);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
